>>> rtl/core/assert_macros.svh
// Assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, held off while reset is asserted
`define CHK_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also runs through reset
`define CHK_CLK_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/core/lsqm_pkg.sv
// Package: request and status codes, widths and controller/datapath interface types
package lsqm_pkg;

    localparam int SLOTS_DEFAULT = 256;

    localparam int REQ_W    = 3;
    localparam int SLOT_W   = 8;
    localparam int CFG_W    = 9;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 9;

    localparam logic [REQ_W-1:0] REQ_ALLOC   = 3'd0;
    localparam logic [REQ_W-1:0] REQ_COMMIT  = 3'd1;
    localparam logic [REQ_W-1:0] REQ_TAKE    = 3'd2;
    localparam logic [REQ_W-1:0] REQ_NEXT    = 3'd3;
    localparam logic [REQ_W-1:0] REQ_RELEASE = 3'd4;

    localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_NO_FREE = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY   = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_BAD     = 2'd3;

    typedef struct packed {
        logic capture;
        logic read;
        logic step;
    } cmd_t;

    typedef struct packed {
        logic walk_more;
    } sts_t;

endpackage

>>> rtl/core/lsqm_datapath.sv
// Datapath: link memory, list heads, batch state, take-batch walker and result register
module lsqm_datapath #(
    parameter int SLOTS = lsqm_pkg::SLOTS_DEFAULT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  lsqm_pkg::cmd_t                cmd,
    output lsqm_pkg::sts_t                sts,
    input  logic [lsqm_pkg::REQ_W-1:0]    req_type,
    input  logic [lsqm_pkg::SLOT_W-1:0]   slot,
    input  logic                          capacity_we,
    input  logic [lsqm_pkg::CFG_W-1:0]    capacity,
    output logic [lsqm_pkg::STATUS_W-1:0] status,
    output logic [lsqm_pkg::SLOT_W-1:0]   slot_out,
    output logic [lsqm_pkg::COUNT_W-1:0]  batch_size,
    output logic                          is_empty,
    output logic                          is_full,
    output logic [lsqm_pkg::COUNT_W-1:0]  available
);

    localparam int IW = $clog2(SLOTS);
    localparam int LW = IW + 1;
    localparam int CW = IW + 1;
    localparam int CAP_RESET = (SLOTS < 256) ? SLOTS : 256;

    localparam logic [LW-1:0] LINK_END  = '1;
    localparam logic [LW-1:0] LINK_USED = LINK_END - LW'(1);

    logic [LW-1:0] link_mem [SLOTS];

    logic [CW-1:0] cap_reg, cap_next;
    logic [CW-1:0] fill_reg, fill_next;
    logic [LW-1:0] free_head_reg, free_head_next;
    logic [LW-1:0] pend_head_reg, pend_head_next;
    logic [CW-1:0] pend_cnt_reg, pend_cnt_next;
    logic [LW-1:0] bfirst_reg, bfirst_next;
    logic [LW-1:0] blast_reg, blast_next;
    logic [LW-1:0] bcursor_reg, bcursor_next;
    logic          bstarted_reg, bstarted_next;
    logic          bheld_reg, bheld_next;

    logic [lsqm_pkg::REQ_W-1:0]  req_type_reg;
    logic [lsqm_pkg::SLOT_W-1:0] slot_reg;

    logic [LW-1:0] walk_cur_reg, walk_cur_next;
    logic [LW-1:0] walk_prev_reg, walk_prev_next;
    logic [CW-1:0] walk_n_reg, walk_n_next;

    logic [LW-1:0] rd_q_reg;
    logic [IW-1:0] rd_idx_reg;
    logic          rd_hit_reg;
    logic          rd_en;
    logic [IW-1:0] rd_addr;
    logic [LW-1:0] rd_link;

    logic          wr_en;
    logic [IW-1:0] wr_addr;
    logic [LW-1:0] wr_data;

    logic [lsqm_pkg::STATUS_W-1:0] res_status, status_reg;
    logic [lsqm_pkg::SLOT_W-1:0]   res_slot, slot_out_reg;
    logic [lsqm_pkg::COUNT_W-1:0]  res_bsize, batch_size_reg;
    logic                          is_empty_reg, is_full_reg;
    logic [lsqm_pkg::COUNT_W-1:0]  available_reg;

    logic          take_ok;
    logic          slot_ok;
    logic          walk_more;
    logic          final_step;
    logic [CW-1:0] cfg_cap;

    function automatic logic link_valid(input logic [LW-1:0] x, input logic [CW-1:0] c);
        return !x[LW-1] && (CW'(x[IW-1:0]) < c);
    endfunction

    function automatic logic [lsqm_pkg::SLOT_W-1:0] to_slot(input logic [IW-1:0] x);
        return lsqm_pkg::SLOT_W'(32'(x));
    endfunction

    // Clamp written capacity into [1, SLOTS]
    always_comb
    begin
        if (capacity == '0)
            cfg_cap = CW'(1);
        else if (32'(capacity) > 32'(SLOTS))
            cfg_cap = CW'(SLOTS);
        else
            cfg_cap = CW'(capacity);
    end

    // Entries past the fill mark read back as their rebuild value
    always_comb
    begin
        if (rd_hit_reg)
            rd_link = rd_q_reg;
        else if (CW'(rd_idx_reg) == cap_reg - CW'(1))
            rd_link = LINK_END;
        else
            rd_link = LW'(rd_idx_reg) + LW'(1);
    end

    assign take_ok    = !bheld_reg && link_valid(pend_head_reg, cap_reg);
    assign slot_ok    = 32'(slot_reg) < 32'(cap_reg);
    assign walk_more  = (req_type_reg == lsqm_pkg::REQ_TAKE) && take_ok
                        && link_valid(rd_link, cap_reg) && (walk_n_reg < cap_reg);
    assign final_step = cmd.step && !walk_more;
    assign sts.walk_more = walk_more;

    always_comb
    begin
        rd_en   = cmd.read || (cmd.step && walk_more);
        rd_addr = '0;
        if (cmd.step)
            rd_addr = rd_link[IW-1:0];
        else
        begin
            unique case (req_type_reg)
                lsqm_pkg::REQ_ALLOC:  rd_addr = free_head_reg[IW-1:0];
                lsqm_pkg::REQ_COMMIT: rd_addr = IW'(slot_reg);
                lsqm_pkg::REQ_TAKE:   rd_addr = pend_head_reg[IW-1:0];
                lsqm_pkg::REQ_NEXT:   rd_addr = bcursor_reg[IW-1:0];
                default:              rd_addr = '0;
            endcase
        end
    end

    always_comb
    begin
        cap_next       = cap_reg;
        fill_next      = fill_reg;
        free_head_next = free_head_reg;
        pend_head_next = pend_head_reg;
        pend_cnt_next  = pend_cnt_reg;
        bfirst_next    = bfirst_reg;
        blast_next     = blast_reg;
        bcursor_next   = bcursor_reg;
        bstarted_next  = bstarted_reg;
        bheld_next     = bheld_reg;
        walk_cur_next  = walk_cur_reg;
        walk_prev_next = walk_prev_reg;
        walk_n_next    = walk_n_reg;
        wr_en          = 1'b0;
        wr_addr        = '0;
        wr_data        = '0;
        res_status     = lsqm_pkg::STATUS_OK;
        res_slot       = '0;
        res_bsize      = '0;

        if (cmd.read)
        begin
            walk_cur_next  = pend_head_reg;
            walk_prev_next = LINK_END;
            walk_n_next    = CW'(1);
        end

        if (cmd.step && walk_more)
        begin
            // Reverse one link and advance
            wr_en          = 1'b1;
            wr_addr        = walk_cur_reg[IW-1:0];
            wr_data        = walk_prev_reg;
            walk_prev_next = walk_cur_reg;
            walk_cur_next  = rd_link;
            walk_n_next    = walk_n_reg + CW'(1);
        end
        else if (cmd.step)
        begin
            unique case (req_type_reg)
                lsqm_pkg::REQ_ALLOC:
                begin
                    if (!link_valid(free_head_reg, cap_reg))
                        res_status = lsqm_pkg::STATUS_NO_FREE;
                    else
                    begin
                        free_head_next = rd_link;
                        wr_en          = 1'b1;
                        wr_addr        = free_head_reg[IW-1:0];
                        wr_data        = LINK_USED;
                        res_slot       = to_slot(free_head_reg[IW-1:0]);
                        if (CW'(free_head_reg[IW-1:0]) == fill_reg)
                            fill_next = fill_reg + CW'(1);
                    end
                end
                lsqm_pkg::REQ_COMMIT:
                begin
                    if (!slot_ok || rd_link != LINK_USED)
                        res_status = lsqm_pkg::STATUS_BAD;
                    else
                    begin
                        wr_en          = 1'b1;
                        wr_addr        = IW'(slot_reg);
                        wr_data        = pend_head_reg;
                        pend_head_next = {1'b0, IW'(slot_reg)};
                        pend_cnt_next  = pend_cnt_reg + CW'(1);
                    end
                end
                lsqm_pkg::REQ_TAKE:
                begin
                    if (bheld_reg)
                        res_status = lsqm_pkg::STATUS_BAD;
                    else if (!link_valid(pend_head_reg, cap_reg))
                        res_status = lsqm_pkg::STATUS_EMPTY;
                    else
                    begin
                        wr_en          = 1'b1;
                        wr_addr        = walk_cur_reg[IW-1:0];
                        wr_data        = walk_prev_reg;
                        bfirst_next    = walk_cur_reg;
                        blast_next     = pend_head_reg;
                        bcursor_next   = LINK_END;
                        bstarted_next  = 1'b0;
                        bheld_next     = 1'b1;
                        pend_head_next = LINK_END;
                        pend_cnt_next  = '0;
                        res_bsize      = lsqm_pkg::COUNT_W'(32'(walk_n_reg));
                    end
                end
                lsqm_pkg::REQ_NEXT:
                begin
                    if (!bheld_reg)
                        res_status = lsqm_pkg::STATUS_BAD;
                    else if (!bstarted_reg)
                    begin
                        bstarted_next = 1'b1;
                        bcursor_next  = bfirst_reg;
                        res_slot      = to_slot(bfirst_reg[IW-1:0]);
                    end
                    else if (!link_valid(bcursor_reg, cap_reg) || !link_valid(rd_link, cap_reg))
                        res_status = lsqm_pkg::STATUS_EMPTY;
                    else
                    begin
                        bcursor_next = rd_link;
                        res_slot     = to_slot(rd_link[IW-1:0]);
                    end
                end
                lsqm_pkg::REQ_RELEASE:
                begin
                    if (!bheld_reg)
                        res_status = lsqm_pkg::STATUS_BAD;
                    else
                    begin
                        if (link_valid(blast_reg, cap_reg))
                        begin
                            wr_en   = 1'b1;
                            wr_addr = blast_reg[IW-1:0];
                            wr_data = free_head_reg;
                        end
                        free_head_next = bfirst_reg;
                        bfirst_next    = LINK_END;
                        blast_next     = LINK_END;
                        bcursor_next   = LINK_END;
                        bstarted_next  = 1'b0;
                        bheld_next     = 1'b0;
                    end
                end
                default:
                    res_status = lsqm_pkg::STATUS_BAD;
            endcase
        end

        // Rebuild the free list and clear the pending list and batch state on a capacity write
        if (capacity_we)
        begin
            cap_next       = cfg_cap;
            fill_next      = '0;
            free_head_next = '0;
            pend_head_next = LINK_END;
            pend_cnt_next  = '0;
            bfirst_next    = LINK_END;
            blast_next     = LINK_END;
            bcursor_next   = LINK_END;
            bstarted_next  = 1'b0;
            bheld_next     = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            link_mem[wr_addr] <= wr_data;
        if (rd_en)
        begin
            rd_q_reg   <= link_mem[rd_addr];
            rd_idx_reg <= rd_addr;
            rd_hit_reg <= CW'(rd_addr) < fill_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            req_type_reg <= req_type;
            slot_reg     <= slot;
        end
        walk_cur_reg  <= walk_cur_next;
        walk_prev_reg <= walk_prev_next;
        walk_n_reg    <= walk_n_next;
        if (final_step)
        begin
            status_reg     <= res_status;
            slot_out_reg   <= res_slot;
            batch_size_reg <= res_bsize;
            is_empty_reg   <= pend_head_next == LINK_END;
            is_full_reg    <= free_head_next == LINK_END;
            available_reg  <= lsqm_pkg::COUNT_W'(32'(cap_reg) - 32'(pend_cnt_next));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg       <= CW'(CAP_RESET);
            fill_reg      <= '0;
            free_head_reg <= '0;
            pend_head_reg <= LINK_END;
            pend_cnt_reg  <= '0;
            bfirst_reg    <= LINK_END;
            blast_reg     <= LINK_END;
            bcursor_reg   <= LINK_END;
            bstarted_reg  <= 1'b0;
            bheld_reg     <= 1'b0;
        end
        else
        begin
            cap_reg       <= cap_next;
            fill_reg      <= fill_next;
            free_head_reg <= free_head_next;
            pend_head_reg <= pend_head_next;
            pend_cnt_reg  <= pend_cnt_next;
            bfirst_reg    <= bfirst_next;
            blast_reg     <= blast_next;
            bcursor_reg   <= bcursor_next;
            bstarted_reg  <= bstarted_next;
            bheld_reg     <= bheld_next;
        end
    end

    assign status     = status_reg;
    assign slot_out   = slot_out_reg;
    assign batch_size = batch_size_reg;
    assign is_empty   = is_empty_reg;
    assign is_full    = is_full_reg;
    assign available  = available_reg;

endmodule

>>> rtl/core/lsqm_ctrl.sv
// Controller: request sequencing and response handshake
module lsqm_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_stall,
    output logic           rsp_valid,
    input  logic           rsp_stall,
    output lsqm_pkg::cmd_t cmd,
    input  lsqm_pkg::sts_t sts
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_READ = 2'd1;
    localparam logic [1:0] ST_EXEC = 2'd2;

    logic [1:0] state_reg, state_next;
    logic       rsp_valid_reg, rsp_valid_next;
    logic       out_free;

    assign out_free = !rsp_valid_reg || !rsp_stall;

    always_comb
    begin
        state_next     = state_reg;
        cmd            = '0;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_READ;
                end
            end
            ST_READ:
            begin
                cmd.read   = 1'b1;
                state_next = ST_EXEC;
            end
            ST_EXEC:
            begin
                if (sts.walk_more)
                    cmd.step = 1'b1;
                else if (out_free)
                begin
                    cmd.step       = 1'b1;
                    rsp_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    assign req_stall = state_reg != ST_IDLE;
    assign rsp_valid = rsp_valid_reg;

endmodule

>>> rtl/core/linked_slot_queue_manager_top.sv
// Top level: linked slot queue manager
// A request goes from acceptance to its response register in order: it is latched, the link
// memory is read through a register, and then the lists are updated. Take-batch walks the
// pending chain one link per cycle through that memory. A new request is accepted while the
// previous response is still stalled; it completes once that response has been taken. No
// clearing pass runs after reset or after a capacity write: a fill mark stands in for the
// rebuilt link values.
module linked_slot_queue_manager_top #(
    parameter int SLOTS = lsqm_pkg::SLOTS_DEFAULT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          req_valid,
    output logic                          req_stall,
    input  logic [lsqm_pkg::REQ_W-1:0]    req_type,
    input  logic [lsqm_pkg::SLOT_W-1:0]   slot,
    output logic                          rsp_valid,
    input  logic                          rsp_stall,
    output logic [lsqm_pkg::STATUS_W-1:0] status,
    output logic [lsqm_pkg::SLOT_W-1:0]   slot_out,
    output logic [lsqm_pkg::COUNT_W-1:0]  batch_size,
    output logic                          is_empty,
    output logic                          is_full,
    output logic [lsqm_pkg::COUNT_W-1:0]  available,
    input  logic                          capacity_we,
    input  logic [lsqm_pkg::CFG_W-1:0]    capacity
);

    lsqm_pkg::cmd_t cmd;
    lsqm_pkg::sts_t sts;

    lsqm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .cmd       (cmd),
        .sts       (sts)
    );

    lsqm_datapath #(
        .SLOTS (SLOTS)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .sts         (sts),
        .req_type    (req_type),
        .slot        (slot),
        .capacity_we (capacity_we),
        .capacity    (capacity),
        .status      (status),
        .slot_out    (slot_out),
        .batch_size  (batch_size),
        .is_empty    (is_empty),
        .is_full     (is_full),
        .available   (available)
    );

endmodule

>>> rtl/core/lsqm_checker.sv
// Port checker for the linked slot queue manager and its bind
`include "assert_macros.svh"

module lsqm_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          req_valid,
    input logic                          req_stall,
    input logic                          rsp_valid,
    input logic                          rsp_stall,
    input logic [lsqm_pkg::STATUS_W-1:0] status,
    input logic [lsqm_pkg::SLOT_W-1:0]   slot_out,
    input logic [lsqm_pkg::COUNT_W-1:0]  batch_size,
    input logic                          is_empty,
    input logic                          is_full,
    input logic [lsqm_pkg::COUNT_W-1:0]  available
);

    `CHK_CLK(a_rsp_hold_valid, rsp_valid && rsp_stall |=> rsp_valid,
             "response dropped while stalled")

    `CHK_CLK(a_rsp_hold_data,
             rsp_valid && rsp_stall |=>
             $stable({status, slot_out, batch_size, is_empty, is_full, available}),
             "stalled response changed")

    `CHK_CLK(a_busy_after_req, req_valid && !req_stall |=> req_stall,
             "second transaction taken while first in flight")

    `CHK_CLK(a_fail_clean,
             rsp_valid && status != lsqm_pkg::STATUS_OK |-> slot_out == '0 && batch_size == '0,
             "failed response carries a slot or batch size")

endmodule

bind linked_slot_queue_manager_top lsqm_checker u_lsqm_checker (.*);
